FILE: hdl/cbdg_pkg.sv
// Shared types, register indexes and constants for the clipped blit descriptor generator.
package cbdg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROWB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_ROWB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_CNT  = 3'd4;

    localparam logic [12:0] ROWB_RESET    = 13'd2;
    localparam logic [3:0]  PLANES_RESET  = 4'd1;
    localparam logic [3:0]  PLANES_MAX    = 4'd8;
    localparam logic [6:0]  WORDS_MAX     = 7'd64;
    localparam logic [10:0] WORD_ROUND    = 11'd15;

    // ceil(2^16 / d): exact floor(n / d) for 13-bit n as (n * r) >> 16
    localparam int RECIP_SHIFT = 16;

    typedef struct packed {
        logic [14:0]        sx;
        logic [14:0]        sy;
        logic [9:0]         w;
        logic [9:0]         h;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [15:0] cminx;
        logic signed [15:0] cminy;
        logic signed [15:0] cmaxx;
        logic signed [15:0] cmaxy;
        logic [3:0]         planes;
    } s1_t;

    typedef struct packed {
        logic [16:0]        sx;
        logic [16:0]        sy;
        logic signed [16:0] minx;
        logic signed [16:0] miny;
        logic signed [17:0] maxx;
        logic signed [17:0] maxy;
        logic [12:0]        sq;
        logic [12:0]        dq;
        logic [3:0]         planes;
    } s2_t;

    typedef struct packed {
        logic               nonempty;
        logic [6:0]         ww;
        logic [9:0]         ch;
        logic [29:0]        sprod;
        logic signed [30:0] dprod;
        logic [13:0]        swoff;
        logic signed [13:0] dwoff;
        logic [12:0]        sq;
        logic [12:0]        dq;
        logic [3:0]         planes;
    } s3_t;

    function automatic logic [3:0] clamp_planes(input logic [3:0] pc);
        logic [3:0] p;
        p = pc;
        if (pc == 4'd0)
        begin
            p = PLANES_RESET;
        end
        else if (pc > PLANES_MAX)
        begin
            p = PLANES_MAX;
        end
        return p;
    endfunction

    function automatic logic [16:0] plane_recip(input logic [3:0] p);
        logic [16:0] r;
        case (p)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/clipped_blit_descriptor_gen.sv
// Top level: four-stage pipelined clip and blitter descriptor setup.
// Path: an input transfer enters stage 1, then stage 2, stage 3 and the output register.
// Throughput: one request per cycle; a full stage waits while its successor stalls.
// Stage 2 and 3 each hold one multiplier per path (reciprocal divide, row offset).
// Reset: valid bits clear; config registers return to base 0, row bytes 2, one plane.
module clipped_blit_descriptor_gen
    import cbdg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [14:0]           src_x,
    input  logic [14:0]           src_y,
    input  logic signed [15:0]    dst_x,
    input  logic signed [15:0]    dst_y,
    input  logic [9:0]            blit_width,
    input  logic [9:0]            blit_height,
    input  logic signed [15:0]    clip_min_x,
    input  logic signed [15:0]    clip_min_y,
    input  logic signed [15:0]    clip_max_x,
    input  logic signed [15:0]    clip_max_y,
    input  logic signed [15:0]    layer_origin_x,
    input  logic signed [15:0]    layer_origin_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  issue,
    output logic [31:0]           src_address,
    output logic [31:0]           dst_address,
    output logic signed [15:0]    src_modulo,
    output logic signed [15:0]    dst_modulo,
    output logic [12:0]           rows_total,
    output logic [6:0]            words_per_row
);

    logic [31:0] src_base_reg;
    logic [31:0] dst_base_reg;
    logic [12:0] src_rowb_reg;
    logic [12:0] dst_rowb_reg;
    logic [3:0]  plane_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_base_reg  <= '0;
            dst_base_reg  <= '0;
            src_rowb_reg  <= ROWB_RESET;
            dst_rowb_reg  <= ROWB_RESET;
            plane_cnt_reg <= PLANES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_BASE:  src_base_reg  <= cfg_data;
                CFG_DST_BASE:  dst_base_reg  <= cfg_data;
                CFG_SRC_ROWB:  src_rowb_reg  <= cfg_data[12:0];
                CFG_DST_ROWB:  dst_rowb_reg  <= cfg_data[12:0];
                CFG_PLANE_CNT: plane_cnt_reg <= cfg_data[3:0];
                default:       ;
            endcase
        end
    end

    // stage handshake: a stage loads when empty or when its successor loads
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: layer offset, plane count clamp
    s1_t s1_reg, s1_next;

    always_comb
    begin
        s1_next.sx     = src_x;
        s1_next.sy     = src_y;
        s1_next.w      = blit_width;
        s1_next.h      = blit_height;
        s1_next.dx     = 17'(dst_x) + 17'(layer_origin_x);
        s1_next.dy     = 17'(dst_y) + 17'(layer_origin_y);
        s1_next.cminx  = clip_min_x;
        s1_next.cminy  = clip_min_y;
        s1_next.cmaxx  = clip_max_x;
        s1_next.cmaxy  = clip_max_y;
        s1_next.planes = clamp_planes(plane_cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid) s1_reg <= s1_next;
    end

    // stage 2: intersect with clip, shift source corner, row bytes per plane
    s2_t s2_reg, s2_next;
    logic signed [16:0] cminx17, cminy17;
    logic signed [17:0] diff_x, diff_y, dxe, dye, cmaxx18, cmaxy18;
    logic               gt_x, gt_y;
    logic [16:0]        recip;
    logic [29:0]        sqprod, dqprod;

    always_comb
    begin
        cminx17 = 17'(s1_reg.cminx);
        cminy17 = 17'(s1_reg.cminy);
        cmaxx18 = 18'(s1_reg.cmaxx);
        cmaxy18 = 18'(s1_reg.cmaxy);
        gt_x    = cminx17 > s1_reg.dx;
        gt_y    = cminy17 > s1_reg.dy;
        diff_x  = 18'(cminx17) - 18'(s1_reg.dx);
        diff_y  = 18'(cminy17) - 18'(s1_reg.dy);
        dxe     = 18'(s1_reg.dx) + 18'($signed({1'b0, s1_reg.w})) - 18'sd1;
        dye     = 18'(s1_reg.dy) + 18'($signed({1'b0, s1_reg.h})) - 18'sd1;
        recip   = plane_recip(s1_reg.planes);
        sqprod  = 30'(src_rowb_reg) * 30'(recip);
        dqprod  = 30'(dst_rowb_reg) * 30'(recip);

        s2_next.sx     = gt_x ? {2'b00, s1_reg.sx} + diff_x[16:0] : {2'b00, s1_reg.sx};
        s2_next.sy     = gt_y ? {2'b00, s1_reg.sy} + diff_y[16:0] : {2'b00, s1_reg.sy};
        s2_next.minx   = gt_x ? cminx17 : s1_reg.dx;
        s2_next.miny   = gt_y ? cminy17 : s1_reg.dy;
        s2_next.maxx   = (cmaxx18 < dxe) ? cmaxx18 : dxe;
        s2_next.maxy   = (cmaxy18 < dye) ? cmaxy18 : dye;
        s2_next.sq     = sqprod[RECIP_SHIFT+12:RECIP_SHIFT];
        s2_next.dq     = dqprod[RECIP_SHIFT+12:RECIP_SHIFT];
        s2_next.planes = s1_reg.planes;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg) s2_reg <= s2_next;
    end

    // stage 3: clipped size, word count, row and word offsets
    s3_t s3_reg, s3_next;
    logic signed [18:0] cw, ch;
    logic [10:0]        cw_round;

    always_comb
    begin
        cw       = 19'(s2_reg.maxx) - 19'(s2_reg.minx) + 19'sd1;
        ch       = 19'(s2_reg.maxy) - 19'(s2_reg.miny) + 19'sd1;
        cw_round = (11'(cw[9:0]) + WORD_ROUND) >> 4;

        s3_next.nonempty = (cw > 19'sd0) && (ch > 19'sd0);
        s3_next.ww       = cw_round[6:0];
        s3_next.ch       = ch[9:0];
        s3_next.sprod    = 30'(s2_reg.sy) * 30'(src_rowb_reg);
        s3_next.dprod    = 31'(s2_reg.miny) * 31'($signed({1'b0, dst_rowb_reg}));
        s3_next.swoff    = {s2_reg.sx[16:4], 1'b0};
        s3_next.dwoff    = $signed({s2_reg.minx[16:4], 1'b0});
        s3_next.sq       = s2_reg.sq;
        s3_next.dq       = s2_reg.dq;
        s3_next.planes   = s2_reg.planes;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg) s3_reg <= s3_next;
    end

    // stage 4: output register; empty area gives all-zero fields
    logic               issue_reg, issue_next;
    logic [31:0]        src_addr_reg, src_addr_next;
    logic [31:0]        dst_addr_reg, dst_addr_next;
    logic signed [15:0] src_mod_reg, src_mod_next;
    logic signed [15:0] dst_mod_reg, dst_mod_next;
    logic [12:0]        rows_reg, rows_next;
    logic [6:0]         wpr_reg, wpr_next;
    logic [15:0]        two_ww;

    always_comb
    begin
        two_ww        = 16'({s3_reg.ww, 1'b0});
        issue_next    = s3_reg.nonempty;
        src_addr_next = '0;
        dst_addr_next = '0;
        src_mod_next  = '0;
        dst_mod_next  = '0;
        rows_next     = '0;
        wpr_next      = '0;
        if (s3_reg.nonempty)
        begin
            src_addr_next = src_base_reg + 32'(s3_reg.sprod) + 32'(s3_reg.swoff);
            dst_addr_next = dst_base_reg + 32'(s3_reg.dprod) + 32'(s3_reg.dwoff);
            src_mod_next  = $signed(16'(s3_reg.sq) - two_ww);
            dst_mod_next  = $signed(16'(s3_reg.dq) - two_ww);
            rows_next     = 13'(s3_reg.ch) * 13'(s3_reg.planes);
            wpr_next      = s3_reg.ww;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            issue_reg    <= issue_next;
            src_addr_reg <= src_addr_next;
            dst_addr_reg <= dst_addr_next;
            src_mod_reg  <= src_mod_next;
            dst_mod_reg  <= dst_mod_next;
            rows_reg     <= rows_next;
            wpr_reg      <= wpr_next;
        end
    end

    assign out_valid     = v4_reg;
    assign issue         = issue_reg;
    assign src_address   = src_addr_reg;
    assign dst_address   = dst_addr_reg;
    assign src_modulo    = src_mod_reg;
    assign dst_modulo    = dst_mod_reg;
    assign rows_total    = rows_reg;
    assign words_per_row = wpr_reg;

endmodule

FILE: hdl/cbdg_checker.sv
// Port-level checks for the clipped blit descriptor generator, bound to the top level.
module cbdg_checker
    import cbdg_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               issue,
    input logic [31:0]        src_address,
    input logic [31:0]        dst_address,
    input logic signed [15:0] src_modulo,
    input logic signed [15:0] dst_modulo,
    input logic [12:0]        rows_total,
    input logic [6:0]         words_per_row
);

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(src_address)
            && $stable(dst_address) && $stable(rows_total) && $stable(issue))
        else $error("result changed while stalled");

    // skipped blit carries no descriptor
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !issue |-> src_address == 32'd0 && dst_address == 32'd0
            && src_modulo == 16'sd0 && dst_modulo == 16'sd0
            && rows_total == 13'd0 && words_per_row == 7'd0)
        else $error("empty clip result has nonzero fields");

    // an issued blit covers at least one word and one row
    a_issue_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && issue |-> words_per_row != 7'd0 && words_per_row <= WORDS_MAX
            && rows_total != 13'd0)
        else $error("issued blit has bad size");

    // at most 1023 rows times eight planes
    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && issue |-> rows_total <= 13'd8184)
        else $error("row count out of range");

endmodule

bind clipped_blit_descriptor_gen cbdg_checker u_cbdg_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for clipped_blit_descriptor_gen: predicts each descriptor and compares.
module testbench;
    import cbdg_pkg::*;

    localparam int PIPE_DRAIN = 8;
    localparam int TIMEOUT    = 3_000_000;

    typedef struct packed {
        logic [14:0]        src_x;
        logic [14:0]        src_y;
        logic signed [15:0] dst_x;
        logic signed [15:0] dst_y;
        logic [9:0]         blit_width;
        logic [9:0]         blit_height;
        logic signed [15:0] clip_min_x;
        logic signed [15:0] clip_min_y;
        logic signed [15:0] clip_max_x;
        logic signed [15:0] clip_max_y;
        logic signed [15:0] layer_origin_x;
        logic signed [15:0] layer_origin_y;
    } blit_req_t;

    localparam int REQ_W = $bits(blit_req_t);

    typedef struct packed {
        logic               issue;
        logic [31:0]        src_address;
        logic [31:0]        dst_address;
        logic signed [15:0] src_modulo;
        logic signed [15:0] dst_modulo;
        logic [12:0]        rows_total;
        logic [6:0]         words_per_row;
    } blit_desc_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [14:0]           src_x = '0;
    logic [14:0]           src_y = '0;
    logic signed [15:0]    dst_x = '0;
    logic signed [15:0]    dst_y = '0;
    logic [9:0]            blit_width = '0;
    logic [9:0]            blit_height = '0;
    logic signed [15:0]    clip_min_x = '0;
    logic signed [15:0]    clip_min_y = '0;
    logic signed [15:0]    clip_max_x = '0;
    logic signed [15:0]    clip_max_y = '0;
    logic signed [15:0]    layer_origin_x = '0;
    logic signed [15:0]    layer_origin_y = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  issue;
    logic [31:0]           src_address;
    logic [31:0]           dst_address;
    logic signed [15:0]    src_modulo;
    logic signed [15:0]    dst_modulo;
    logic [12:0]           rows_total;
    logic [6:0]            words_per_row;

    // shadow copy of the register file
    logic [31:0] model_src_base = '0;
    logic [31:0] model_dst_base = '0;
    logic [12:0] model_src_rowb = ROWB_RESET;
    logic [12:0] model_dst_rowb = ROWB_RESET;
    logic [3:0]  model_planes   = PLANES_RESET;

    blit_desc_t pending_descriptors[$];
    int         mismatch_count = 0;
    bit         throttle_source = 1'b0;
    bit         throttle_sink = 1'b0;
    int         ready_run = 0;
    int         stall_run = 0;

    clipped_blit_descriptor_gen dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .src_x          (src_x),
        .src_y          (src_y),
        .dst_x          (dst_x),
        .dst_y          (dst_y),
        .blit_width     (blit_width),
        .blit_height    (blit_height),
        .clip_min_x     (clip_min_x),
        .clip_min_y     (clip_min_y),
        .clip_max_x     (clip_max_x),
        .clip_max_y     (clip_max_y),
        .layer_origin_x (layer_origin_x),
        .layer_origin_y (layer_origin_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .issue          (issue),
        .src_address    (src_address),
        .dst_address    (dst_address),
        .src_modulo     (src_modulo),
        .dst_modulo     (dst_modulo),
        .rows_total     (rows_total),
        .words_per_row  (words_per_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT);
        $display("TEST FAILED");
        $finish;
    end

    function automatic blit_desc_t compute_descriptor(input blit_req_t r);
        blit_desc_t d;
        longint sx, sy, dx, dy, left, top, right, bottom, cw, ch, ww, np, soff, doff;
        d = '0;
        sx = longint'(r.src_x);
        sy = longint'(r.src_y);
        dx = longint'($signed(r.dst_x)) + longint'($signed(r.layer_origin_x));
        dy = longint'($signed(r.dst_y)) + longint'($signed(r.layer_origin_y));
        // clipping on the left/top pulls the source corner along
        left = longint'($signed(r.clip_min_x));
        if (left > dx)
            sx = sx + (left - dx);
        else
            left = dx;
        top = longint'($signed(r.clip_min_y));
        if (top > dy)
            sy = sy + (top - dy);
        else
            top = dy;
        right = longint'($signed(r.clip_max_x));
        if (dx + longint'(r.blit_width) - 1 < right)
            right = dx + longint'(r.blit_width) - 1;
        bottom = longint'($signed(r.clip_max_y));
        if (dy + longint'(r.blit_height) - 1 < bottom)
            bottom = dy + longint'(r.blit_height) - 1;
        cw = right - left + 1;
        ch = bottom - top + 1;
        if (cw > 0 && ch > 0)
        begin
            np = longint'(model_planes);
            if (np < 1)
                np = 1;
            if (np > longint'(PLANES_MAX))
                np = longint'(PLANES_MAX);
            ww = (cw + longint'(WORD_ROUND)) >>> 4;
            // arithmetic shift gives floor for negative corners
            soff = sy * longint'(model_src_rowb) + (sx >>> 4) * 2;
            doff = top * longint'(model_dst_rowb) + (left >>> 4) * 2;
            d.issue         = 1'b1;
            d.src_address   = 32'(longint'(model_src_base) + soff);
            d.dst_address   = 32'(longint'(model_dst_base) + doff);
            d.src_modulo    = 16'(longint'(model_src_rowb) / np - 2 * ww);
            d.dst_modulo    = 16'(longint'(model_dst_rowb) / np - 2 * ww);
            d.rows_total    = 13'(ch * np);
            d.words_per_row = 7'(ww);
        end
        return d;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return 16'(v);
    endfunction

    function automatic logic [15:0] edge_value16();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // one axis of a plausible request: destination near the clip window
    task automatic pick_axis(output logic signed [15:0] pos, org, lo, hi,
                             output logic [9:0] len);
        int o, a, l, c0, c1;
        o = int'($urandom_range(0, 32767)) - 16384;
        a = int'($urandom_range(0, 32767)) - 16384;
        if ($urandom_range(0, 9) < 7)
            l = $urandom_range(1, 200);
        else
            l = $urandom_range(0, 1023);
        c0 = a - 400 + int'($urandom_range(0, 400 + l));
        c1 = c0 + int'($urandom_range(0, 1300)) - 40;
        pos = 16'(a - o);
        org = 16'(o);
        lo  = sat16(c0);
        hi  = sat16(c1);
        len = 10'(l);
    endtask

    task automatic random_request(output blit_req_t r);
        int roll;
        roll = $urandom_range(0, 99);
        r.src_x = 15'($urandom);
        r.src_y = 15'($urandom);
        if (roll < 65)
        begin
            pick_axis(r.dst_x, r.layer_origin_x, r.clip_min_x, r.clip_max_x, r.blit_width);
            pick_axis(r.dst_y, r.layer_origin_y, r.clip_min_y, r.clip_max_y, r.blit_height);
        end
        else if (roll < 85)
        begin
            r = blit_req_t'(REQ_W'({$urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom}));
        end
        else
        begin
            r.src_x          = 15'(edge_value16());
            r.src_y          = 15'(edge_value16());
            r.dst_x          = edge_value16();
            r.dst_y          = edge_value16();
            r.blit_width     = 10'(edge_value16());
            r.blit_height    = 10'(edge_value16());
            r.clip_min_x     = edge_value16();
            r.clip_min_y     = edge_value16();
            r.clip_max_x     = edge_value16();
            r.clip_max_y     = edge_value16();
            r.layer_origin_x = edge_value16();
            r.layer_origin_y = edge_value16();
        end
    endtask

    function automatic blit_req_t make_req(input int sx, sy, dx, dy, w, h,
                                           input int cx0, cy0, cx1, cy1, ox, oy);
        blit_req_t r;
        r.src_x          = 15'(sx);
        r.src_y          = 15'(sy);
        r.dst_x          = 16'(dx);
        r.dst_y          = 16'(dy);
        r.blit_width     = 10'(w);
        r.blit_height    = 10'(h);
        r.clip_min_x     = 16'(cx0);
        r.clip_min_y     = 16'(cy0);
        r.clip_max_x     = 16'(cx1);
        r.clip_max_y     = 16'(cy1);
        r.layer_origin_x = 16'(ox);
        r.layer_origin_y = 16'(oy);
        return r;
    endfunction

    task automatic push_request(input blit_req_t r);
        int gap;
        gap = throttle_source ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        src_x          <= r.src_x;
        src_y          <= r.src_y;
        dst_x          <= r.dst_x;
        dst_y          <= r.dst_y;
        blit_width     <= r.blit_width;
        blit_height    <= r.blit_height;
        clip_min_x     <= r.clip_min_x;
        clip_min_y     <= r.clip_min_y;
        clip_max_x     <= r.clip_max_x;
        clip_max_y     <= r.clip_max_y;
        layer_origin_x <= r.layer_origin_x;
        layer_origin_y <= r.layer_origin_y;
        do @(posedge clk); while (!in_ready);
        pending_descriptors.push_back(compute_descriptor(r));
    endtask

    task automatic push_random(input int count);
        blit_req_t r;
        repeat (count)
        begin
            random_request(r);
            push_request(r);
        end
    endtask

    // drain everything in flight before touching registers
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (pending_descriptors.size() != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // leaves cfg_we high; the caller drops it after the last write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_SRC_BASE:  model_src_base = data;
            CFG_DST_BASE:  model_dst_base = data;
            CFG_SRC_ROWB:  model_src_rowb = data[12:0];
            CFG_DST_ROWB:  model_dst_rowb = data[12:0];
            CFG_PLANE_CNT: model_planes = data[3:0];
            default: ;
        endcase
    endtask

    task automatic program_block(input logic [31:0] sb, db, input logic [12:0] srb, drb,
                                 input logic [3:0] pc);
        settle_pipeline();
        // junk above the row byte and plane count register widths must be dropped
        write_register(CFG_SRC_BASE, sb);
        write_register(CFG_DST_BASE, db);
        write_register(CFG_SRC_ROWB, {19'($urandom), srb});
        write_register(CFG_DST_ROWB, {19'($urandom), drb});
        write_register(CFG_PLANE_CNT, {28'($urandom), pc});
        cfg_we <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want, got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // checks every output transfer and drives the sink stall pattern
    always @(posedge clk)
    begin : result_check
        blit_desc_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_descriptors.size() == 0)
            begin
                $error("output transfer with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_descriptors.pop_front();
                compare_field("issue", want.issue, issue);
                compare_field("src_address", want.src_address, src_address);
                compare_field("dst_address", want.dst_address, dst_address);
                compare_field("src_modulo", want.src_modulo, src_modulo);
                compare_field("dst_modulo", want.dst_modulo, dst_modulo);
                compare_field("rows_total", want.rows_total, rows_total);
                compare_field("words_per_row", want.words_per_row, words_per_row);
            end
        end
        if (!throttle_sink)
        begin
            out_ready <= 1'b1;
        end
        else if (ready_run > 0)
        begin
            ready_run--;
            out_ready <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            out_ready <= 1'b0;
        end
        else
        begin
            ready_run = $urandom_range(0, 24);
            stall_run = pick_gap();
            out_ready <= 1'b1;
        end
    end

    // register values straight out of reset
    task automatic test_reset_defaults();
        throttle_source = 1'b0;
        throttle_sink   = 1'b0;
        push_request(make_req(40, 3, 10, 20, 64, 16, 0, 0, 319, 199, 0, 0));
        push_request(make_req(0, 0, -37, -1, 100, 20, -100, -50, 319, 199, 0, 0));
        push_random(6);
    endtask

    task automatic test_directed_cases();
        program_block(32'h0004_0000, 32'hfff0_0000, 13'd120, 13'd240, 4'd3);
        throttle_source = 1'b1;
        throttle_sink   = 1'b1;
        push_request(make_req(0, 0, 10, 20, 64, 16, 0, 0, 319, 199, 0, 0));
        push_request(make_req(32, 8, 10, 20, 0, 16, 0, 0, 319, 199, 0, 0));
        push_request(make_req(32, 8, 10, 20, 48, 0, 0, 0, 319, 199, 0, 0));
        push_request(make_req(16, 0, -5, 3, 40, 10, 0, 0, 319, 199, 0, 0));
        push_request(make_req(0, 16, 3, -7, 40, 10, 0, 0, 319, 199, 0, 0));
        push_request(make_req(0, 0, 400, 10, 32, 8, 0, 0, 319, 199, 0, 0));
        push_request(make_req(0, 0, 10, 300, 32, 8, 0, 0, 319, 199, 0, 0));
        // clip window inverted: always empty
        push_request(make_req(0, 0, 10, 10, 32, 8, 100, 100, 50, 50, 0, 0));
        push_request(make_req(5, 5, 7, 9, 1, 1, 0, 0, 319, 199, 0, 0));
        push_request(make_req(0, 0, -512, -512, 1023, 1023,
                              -32768, -32768, 32767, 32767, 0, 0));
        push_request(make_req(0, 0, -37, -1, 100, 20, -100, -50, 319, 199, 0, 0));
        // layer origin pushes the corner outside 16 bits
        push_request(make_req(0, 0, 32767, 32767, 100, 100,
                              -32768, -32768, 32767, 32767, 32767, 32767));
        push_request(make_req(0, 0, -32768, -32768, 1023, 1023,
                              -32768, -32768, 32767, 32767, -32768, -32768));
        push_request(make_req(0, 0, -32768, -32768, 1023, 1023,
                              -32768, -32768, 32767, 32767, 0, 0));
        push_request(make_req(32767, 32767, 0, 0, 1023, 1023, 1000, 1000, 1010, 1010, 0, 0));
        push_request(make_req(0, 0, 0, 0, 15, 1, 0, 0, 319, 199, 0, 0));
        push_request(make_req(0, 0, 0, 0, 16, 1, 0, 0, 319, 199, 0, 0));
        push_request(make_req(0, 0, 0, 0, 17, 1, 0, 0, 319, 199, 0, 0));
        push_request(make_req(48, 4, 50, 60, 30, 20, 50, 60, 79, 79, 0, 0));
        push_request(make_req(0, 0, 100, 100, 200, 200, 150, 120, 180, 140, 0, 0));
        push_request(make_req(0, 0, 10, 10, 50, 50, -32768, -32768, 32767, 32767, -20, 30));
        push_request(make_req(0, 0, 32767, 0, 10, 10,
                              -32768, -32768, 32767, 32767, -32768, 0));
    endtask

    // writes to unmapped indexes must leave the register file alone
    task automatic test_unmapped_index();
        program_block($urandom, $urandom, 13'($urandom_range(2, 4096)),
                      13'($urandom_range(2, 4096)), 4'($urandom_range(1, 8)));
        push_random(5);
        settle_pipeline();
        for (int i = int'(CFG_PLANE_CNT) + 1; i < (1 << CFG_IDX_W); i++)
            write_register(CFG_IDX_W'(i), $urandom);
        cfg_we <= 1'b0;
        push_random(10);
    endtask

    // plane count clamping and row byte values outside the usual range
    task automatic test_plane_count_limits();
        logic [3:0]  plane_set [8] = '{4'd0, 4'd9, 4'd15, 4'd8, 4'd1, 4'd3, 4'd5, 4'd7};
        logic [12:0] srb_set [8]   = '{13'd0, 13'd8191, 13'd1, 13'd4096,
                                       13'd2, 13'd100, 13'd7, 13'd8190};
        logic [12:0] drb_set [8]   = '{13'd1, 13'd8191, 13'd0, 13'd2,
                                       13'd4096, 13'd99, 13'd4095, 13'd13};
        throttle_source = 1'b1;
        throttle_sink   = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            program_block($urandom, $urandom, srb_set[k], drb_set[k], plane_set[k]);
            push_random(8);
        end
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: program_block(32'h0, 32'h0, 13'd2, 13'd2, 4'd1);
                1: program_block(32'hffff_ffff, 32'hffff_ffff, 13'd4096, 13'd4096, 4'd8);
                default:
                    program_block($urandom, $urandom,
                        ($urandom_range(0, 9) == 0) ? 13'($urandom)
                                                    : 13'($urandom_range(2, 4096)),
                        ($urandom_range(0, 9) == 0) ? 13'($urandom)
                                                    : 13'($urandom_range(2, 4096)),
                        ($urandom_range(0, 9) == 0) ? 4'($urandom)
                                                    : 4'($urandom_range(1, 8)));
            endcase
            throttle_source = (p % 2 == 1) || (p >= 4);
            throttle_sink   = (p >= 2);
            push_random(300);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_cases();
        test_unmapped_index();
        test_plane_count_limits();
        test_random_traffic();
        settle_pipeline();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/cbdg_pkg.sv
hdl/clipped_blit_descriptor_gen.sv
hdl/cbdg_checker.sv
tb/testbench.sv
